[rtl/assert_macros.svh]
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that is also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/mmm_pkg.sv]
// Shared constants and types of the motor mixer
package mmm_pkg;

  // Motor slots on the output bus, and motors actually driven
  localparam int MAX_MOTORS = 8;
  localparam int MOTOR_COUNT = 8;
  localparam int SPEED_W = 12;
  localparam int CMD_W = 16;
  localparam int PROD_W = 29;

  // Action codes carried in the input tuser
  localparam logic [1:0] ACT_MIX    = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_FSTATE = 2'd2;
  localparam logic [1:0] ACT_STICK  = 2'd3;

  // Flight states
  localparam logic [2:0] FM_DISARMED = 3'd0;
  localparam logic [2:0] FM_ARMED    = 3'd1;
  localparam logic [2:0] FM_READY    = 3'd2;
  localparam logic [2:0] FM_TESTING  = 3'd3;

  // Configuration register indexes
  localparam logic CFG_MIN_SPEED = 1'b0;
  localparam logic CFG_MAX_SPEED = 1'b1;

  // Kind of result produced by an item in flight
  localparam logic [1:0] KIND_MIX  = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;
  localparam logic [1:0] KIND_TEST = 2'd3;

  // Motor test scale: stick is Q11.4 and full deflection is 90, so 90 * 16
  localparam int TEST_SCALE = 1440;
  localparam int SCALE_W = 23;           // holds 4095 * 1440
  // floor(x / 45) = (x * RECIP_45) >> 24, exact for x below 2**18
  localparam int QUOT_X_W = 18;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = 19;
  localparam logic [RECIP_W-1:0] RECIP_45 = 19'd372828;

  // Sign pattern per motor, bit i set where the term is subtracted
  localparam logic [MAX_MOTORS-1:0] ROLL_NEG  = 8'h99;
  localparam logic [MAX_MOTORS-1:0] PITCH_NEG = 8'h33;
  localparam logic [MAX_MOTORS-1:0] YAW_NEG   = 8'h5A;

  typedef struct packed {
    logic roll_neg;
    logic pitch_neg;
    logic yaw_neg;
  } sign_t;

  typedef struct packed {
    logic s2_ld;
    logic out_ld;
  } lane_ctrl_t;

endpackage

[rtl/mmm_lane.sv]
// One motor lane: mix and range stage, then test divide and result register
module mmm_lane (
  input  logic                                  clk,
  input  mmm_pkg::lane_ctrl_t                   ctrl,
  input  mmm_pkg::sign_t                        sgn,
  input  logic [1:0]                            kind,
  input  logic signed [mmm_pkg::CMD_W-1:0]      thrust,
  input  logic signed [mmm_pkg::CMD_W-1:0]      roll_cmd,
  input  logic signed [mmm_pkg::CMD_W-1:0]      pitch_cmd,
  input  logic signed [mmm_pkg::CMD_W-1:0]      yaw_cmd,
  input  logic signed [mmm_pkg::PROD_W-1:0]     prod,
  input  logic [mmm_pkg::SPEED_W-1:0]           idle_speed,
  input  logic [mmm_pkg::SPEED_W-1:0]           speed_limit,
  output logic [mmm_pkg::SPEED_W-1:0]           speed
);

  logic signed [19:0] base;
  logic signed [19:0] th_t;
  logic signed [19:0] roll_t;
  logic signed [19:0] pitch_t;
  logic signed [19:0] yaw_t;
  logic signed [19:0] sum;
  logic signed [19:0] neg_sum;
  logic signed [19:0] v;
  logic signed [19:0] min_s;
  logic signed [19:0] max_s;
  logic [mmm_pkg::SPEED_W-1:0] mix_val;

  logic [mmm_pkg::SCALE_W-1:0] min_scaled;
  logic [mmm_pkg::SCALE_W-1:0] max_scaled;
  logic signed [mmm_pkg::PROD_W-1:0] t;

  // stage 2 registers
  logic [1:0] kind2;
  logic [mmm_pkg::SPEED_W-1:0] mix2;
  logic neg2;
  logic over2;
  logic [mmm_pkg::QUOT_X_W-1:0] x2;

  logic [mmm_pkg::QUOT_X_W+mmm_pkg::RECIP_W-1:0] quot_prod;
  logic [mmm_pkg::SPEED_W-1:0] quot;

  // Signed sum of terms around the idle speed, in 1/16 steps
  always_comb begin
    base    = signed'({4'b0000, idle_speed, 4'b0000});
    th_t    = {{4{thrust[15]}}, thrust};
    roll_t  = {{4{roll_cmd[15]}}, roll_cmd};
    pitch_t = {{4{pitch_cmd[15]}}, pitch_cmd};
    yaw_t   = {{4{yaw_cmd[15]}}, yaw_cmd};
    if (sgn.roll_neg) begin
      roll_t = -roll_t;
    end
    if (sgn.pitch_neg) begin
      pitch_t = -pitch_t;
    end
    if (sgn.yaw_neg) begin
      yaw_t = -yaw_t;
    end
    sum = base + th_t + roll_t + pitch_t + yaw_t;
    neg_sum = -sum;
    // truncate toward zero
    if (sum[19]) begin
      v = -(neg_sum >>> 4);
    end else begin
      v = sum >>> 4;
    end
    min_s = signed'({8'b0, idle_speed});
    max_s = signed'({8'b0, speed_limit});
    // lower clamp wins when min is above max
    if (v < min_s) begin
      mix_val = idle_speed;
    end else if (v > max_s) begin
      mix_val = speed_limit;
    end else begin
      mix_val = v[mmm_pkg::SPEED_W-1:0];
    end
  end

  // Motor test numerator and its range checks
  always_comb begin
    min_scaled = mmm_pkg::SCALE_W'(idle_speed) * mmm_pkg::SCALE_W'(mmm_pkg::TEST_SCALE);
    max_scaled = mmm_pkg::SCALE_W'(speed_limit) * mmm_pkg::SCALE_W'(mmm_pkg::TEST_SCALE);
    t = prod + signed'({{(mmm_pkg::PROD_W-mmm_pkg::SCALE_W){1'b0}}, min_scaled});
  end

  // Hold the stage 2 results
  always_ff @(posedge clk) begin
    if (ctrl.s2_ld) begin
      kind2 <= kind;
      mix2  <= mix_val;
      neg2  <= t[mmm_pkg::PROD_W-1];
      over2 <= t > signed'({{(mmm_pkg::PROD_W-mmm_pkg::SCALE_W){1'b0}}, max_scaled});
      // divide by 32 here, by 45 below
      x2    <= t[mmm_pkg::QUOT_X_W+4:5];
    end
  end

  // Divide by 45 through the reciprocal
  always_comb begin
    quot_prod = (mmm_pkg::QUOT_X_W+mmm_pkg::RECIP_W)'(x2)
              * (mmm_pkg::QUOT_X_W+mmm_pkg::RECIP_W)'(mmm_pkg::RECIP_45);
    quot = quot_prod[mmm_pkg::RECIP_SHIFT+mmm_pkg::SPEED_W-1:mmm_pkg::RECIP_SHIFT];
  end

  // Select the result for this motor
  always_ff @(posedge clk) begin
    if (ctrl.out_ld) begin
      case (kind2)
        mmm_pkg::KIND_MIX:  speed <= mix2;
        mmm_pkg::KIND_ZERO: speed <= '0;
        mmm_pkg::KIND_IDLE: speed <= idle_speed;
        mmm_pkg::KIND_TEST: begin
          if (neg2) begin
            speed <= '0;
          end else if (over2) begin
            speed <= speed_limit;
          end else begin
            speed <= quot;
          end
        end
        default: speed <= '0;
      endcase
    end
  end

endmodule

[rtl/multirotor_motor_mixer_top.sv]
// Eight-motor mixer top level: input stage, flight state, lanes and output register
// Takes one item per clock while the output is not stalled and returns each result
// through its registered stages: the stick product register, the per-motor mix and
// range register, and the output register fed by the divide-by-45 reciprocal
// multiply. A mix command (tuser 0) and a scheduler tick in the disarmed, armed,
// ready or testing state each yield one result; flight state (tuser 2) and stick
// updates (tuser 3) only change state and take effect for the next item.
// Configuration writes are taken at any time but must only be made while no
// item is in flight. There is no start-up sweep after reset.
module multirotor_motor_mixer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // thrust, roll_cmd, pitch_cmd, yaw_cmd, new_flight_state
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // speed_m1 .. speed_m8, 12 bits each
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int W = mmm_pkg::SPEED_W;

  logic [W-1:0] idle_speed;
  logic [W-1:0] speed_limit;
  logic [2:0]   flight_mode;
  logic signed [15:0] stick_yaw;
  logic signed [15:0] stick_alt;
  logic signed [15:0] stick_roll;
  logic signed [15:0] stick_pitch;

  logic signed [15:0] in_thrust;
  logic signed [15:0] in_roll;
  logic signed [15:0] in_pitch;
  logic signed [15:0] in_yaw;
  logic [2:0]         in_fstate;
  logic [1:0]         action;

  logic in_acc;
  logic has_res;
  logic [1:0] kind_in;
  logic signed [12:0] span;
  logic signed [mmm_pkg::PROD_W-1:0] prod_in [4];

  // stage 1 registers
  logic s1_v;
  logic [1:0] s1_kind;
  logic signed [15:0] s1_thrust;
  logic signed [15:0] s1_roll;
  logic signed [15:0] s1_pitch;
  logic signed [15:0] s1_yaw;
  logic signed [mmm_pkg::PROD_W-1:0] s1_prod [4];

  logic s2_v;
  logic out_free;
  logic s2_free;
  logic s1_free;
  mmm_pkg::lane_ctrl_t ctrl;
  logic [W-1:0] speed [mmm_pkg::MAX_MOTORS];

  assign in_thrust = s_axis_tdata[15:0];
  assign in_roll   = s_axis_tdata[31:16];
  assign in_pitch  = s_axis_tdata[47:32];
  assign in_yaw    = s_axis_tdata[63:48];
  assign in_fstate = s_axis_tdata[66:64];
  assign action    = s_axis_tuser;

  // Stage hand-off: each stage loads when the one after it can move
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s2_free       = !s2_v || out_free;
  assign s1_free       = !s1_v || s2_free;
  assign s_axis_tready = s1_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ctrl.s2_ld    = s1_v && s2_free;
  assign ctrl.out_ld   = s2_v && out_free;

  // Decide whether the item yields a result, and of which kind
  always_comb begin
    has_res = 1'b0;
    kind_in = mmm_pkg::KIND_MIX;
    case (action)
      mmm_pkg::ACT_MIX: begin
        has_res = 1'b1;
        kind_in = mmm_pkg::KIND_MIX;
      end
      mmm_pkg::ACT_TICK: begin
        case (flight_mode)
          mmm_pkg::FM_DISARMED, mmm_pkg::FM_ARMED: begin
            has_res = 1'b1;
            kind_in = mmm_pkg::KIND_ZERO;
          end
          mmm_pkg::FM_READY: begin
            has_res = 1'b1;
            kind_in = mmm_pkg::KIND_IDLE;
          end
          mmm_pkg::FM_TESTING: begin
            has_res = 1'b1;
            kind_in = mmm_pkg::KIND_TEST;
          end
          default: has_res = 1'b0;
        endcase
      end
      default: has_res = 1'b0;
    endcase
  end

  // Scale each stored stick by the speed span
  always_comb begin
    span = signed'({1'b0, speed_limit}) - signed'({1'b0, idle_speed});
    prod_in[0] = $signed(stick_yaw) * span;
    prod_in[1] = $signed(stick_alt) * span;
    prod_in[2] = $signed(stick_roll) * span;
    prod_in[3] = $signed(stick_pitch) * span;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_speed  <= 12'd150;
      speed_limit <= 12'd1800;
    end else if (cfg_we) begin
      case (cfg_index)
        mmm_pkg::CFG_MIN_SPEED: idle_speed  <= cfg_wdata;
        mmm_pkg::CFG_MAX_SPEED: speed_limit <= cfg_wdata;
        default: idle_speed <= idle_speed;
      endcase
    end
  end

  // Flight state and stick updates
  always_ff @(posedge clk) begin
    if (rst) begin
      flight_mode <= mmm_pkg::FM_DISARMED;
      stick_yaw   <= '0;
      stick_alt   <= '0;
      stick_roll  <= '0;
      stick_pitch <= '0;
    end else if (in_acc) begin
      if (action == mmm_pkg::ACT_FSTATE) begin
        flight_mode <= in_fstate;
      end
      if (action == mmm_pkg::ACT_STICK) begin
        stick_alt   <= in_thrust;
        stick_roll  <= in_roll;
        stick_pitch <= in_pitch;
        stick_yaw   <= in_yaw;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc && s1_free) begin
      s1_kind   <= kind_in;
      s1_thrust <= in_thrust;
      s1_roll   <= in_roll;
      s1_pitch  <= in_pitch;
      s1_yaw    <= in_yaw;
      for (int k = 0; k < 4; k++) begin
        s1_prod[k] <= prod_in[k];
      end
    end
  end

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      s2_v          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v <= in_acc && has_res;
      end
      if (s2_free) begin
        s2_v <= s1_v;
      end
      if (out_free) begin
        m_axis_tvalid <= s2_v;
      end
    end
  end

  // Motor lanes; unused slots read zero
  for (genvar i = 0; i < mmm_pkg::MAX_MOTORS; i++) begin : g_motor
    if (i < mmm_pkg::MOTOR_COUNT) begin : g_used
      mmm_pkg::sign_t sgn;
      assign sgn.roll_neg  = mmm_pkg::ROLL_NEG[i];
      assign sgn.pitch_neg = mmm_pkg::PITCH_NEG[i];
      assign sgn.yaw_neg   = mmm_pkg::YAW_NEG[i];

      mmm_lane u_lane (
        .clk         (clk),
        .ctrl        (ctrl),
        .sgn         (sgn),
        .kind        (s1_kind),
        .thrust      (s1_thrust),
        .roll_cmd    (s1_roll),
        .pitch_cmd   (s1_pitch),
        .yaw_cmd     (s1_yaw),
        .prod        (s1_prod[i % 4]),
        .idle_speed  (idle_speed),
        .speed_limit (speed_limit),
        .speed       (speed[i])
      );
    end else begin : g_unused
      assign speed[i] = '0;
    end
    assign m_axis_tdata[i*W +: W] = speed[i];
  end

endmodule

[rtl/mmm_checker.sv]
// Port-level checks on the motor mixer, bound to the top level
`include "assert_macros.svh"

module mmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  logic mix_in;
  assign mix_in = s_axis_tvalid && s_axis_tready && (s_axis_tuser == mmm_pkg::ACT_MIX);

  // No result is shown straight after reset
  `ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_axis_tvalid)

  // A stalled result holds its speeds
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // Input back-pressure only comes from a stalled output
  `ASSERT_NOW(a_bp, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // A mix command reaches the output while the receiver stays ready
  `ASSERT_NEXT(a_latency, clk, rst, (mix_in && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready, m_axis_tvalid)

endmodule

bind multirotor_motor_mixer_top mmm_checker u_mmm_checker (.*);

[tb/sv/mmm_mixer_checker.sv]
// Scoreboard for the motor mixer: predicts each result from the input transfers and checks the output
module mmm_mixer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // thrust, roll_cmd, pitch_cmd, yaw_cmd, new_flight_state
  input  logic [1:0]  s_axis_tuser,   // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,   // speed_m1 .. speed_m8, 12 bits each
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Motors that subtract each term (bit 0 is motor 1)
  localparam logic [7:0] ROLL_SUB  = 8'b1001_1001;
  localparam logic [7:0] PITCH_SUB = 8'b0011_0011;
  localparam logic [7:0] YAW_SUB   = 8'b0101_1010;
  // Full stick deflection of 90 in Q11.4
  localparam longint STICK_FULL = 1440;

  logic [11:0]        min_spd;
  logic [11:0]        max_spd;
  logic [2:0]         fmode;
  logic signed [15:0] stick_alt;
  logic signed [15:0] stick_roll;
  logic signed [15:0] stick_pitch;
  logic signed [15:0] stick_yaw;
  logic [95:0]        speeds_due[$];

  // Idle speed plus the signed terms, truncated toward zero, then clamped
  function automatic logic [11:0] mixed_speed(int m, logic signed [15:0] th,
                                               logic signed [15:0] r, logic signed [15:0] p,
                                               logic signed [15:0] y);
    int acc;
    int v;
    acc = int'(min_spd) * 16 + int'(th);
    acc += ROLL_SUB[m]  ? -int'(r) : int'(r);
    acc += PITCH_SUB[m] ? -int'(p) : int'(p);
    acc += YAW_SUB[m]   ? -int'(y) : int'(y);
    v = acc / 16;
    if (v < int'(min_spd))
      v = int'(min_spd);
    else if (v > int'(max_spd))
      v = int'(max_spd);
    return 12'(v);
  endfunction

  // Motor test speed: idle plus the stick share of the span, exact arithmetic
  function automatic logic [11:0] test_speed(logic signed [15:0] stick);
    longint t;
    t = longint'(min_spd) * STICK_FULL
        + longint'(stick) * (longint'(max_spd) - longint'(min_spd));
    if (t < 0)
      return '0;
    if (t > longint'(max_spd) * STICK_FULL)
      return max_spd;
    return 12'(t / STICK_FULL);
  endfunction

  always @(posedge clk) begin : watch
    logic [95:0]        want;
    logic signed [15:0] th;
    logic signed [15:0] r;
    logic signed [15:0] p;
    logic signed [15:0] y;
    logic signed [15:0] st;
    logic [11:0]        got_spd;
    logic [11:0]        want_spd;
    if (rst) begin
      min_spd     = 12'd150;
      max_spd     = 12'd1800;
      fmode       = mmm_pkg::FM_DISARMED;
      stick_alt   = '0;
      stick_roll  = '0;
      stick_pitch = '0;
      stick_yaw   = '0;
      speeds_due.delete();
      mismatches  = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == mmm_pkg::CFG_MIN_SPEED)
          min_spd = cfg_wdata;
        else
          max_spd = cfg_wdata;
      end

      // Predict from each input transfer
      if (s_axis_tvalid && s_axis_tready) begin
        th = s_axis_tdata[15:0];
        r  = s_axis_tdata[31:16];
        p  = s_axis_tdata[47:32];
        y  = s_axis_tdata[63:48];
        case (s_axis_tuser)
          mmm_pkg::ACT_MIX: begin
            for (int m = 0; m < 8; m++)
              want[m*12 +: 12] = (m < mmm_pkg::MOTOR_COUNT) ? mixed_speed(m, th, r, p, y) : '0;
            speeds_due.push_back(want);
          end
          mmm_pkg::ACT_FSTATE: fmode = s_axis_tdata[66:64];
          mmm_pkg::ACT_STICK: begin
            stick_alt   = th;
            stick_roll  = r;
            stick_pitch = p;
            stick_yaw   = y;
          end
          default: begin
            case (fmode)
              mmm_pkg::FM_DISARMED, mmm_pkg::FM_ARMED: speeds_due.push_back('0);
              mmm_pkg::FM_READY: begin
                for (int m = 0; m < 8; m++)
                  want[m*12 +: 12] = (m < mmm_pkg::MOTOR_COUNT) ? min_spd : '0;
                speeds_due.push_back(want);
              end
              mmm_pkg::FM_TESTING: begin
                for (int m = 0; m < 8; m++) begin
                  case (m % 4)
                    0:       st = stick_yaw;
                    1:       st = stick_alt;
                    2:       st = stick_roll;
                    default: st = stick_pitch;
                  endcase
                  want[m*12 +: 12] = (m < mmm_pkg::MOTOR_COUNT) ? test_speed(st) : '0;
                end
                speeds_due.push_back(want);
              end
              default: ;  // flying states stay silent on a tick
            endcase
          end
        endcase
      end

      // Compare each output transfer with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (speeds_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        end else begin
          want = speeds_due.pop_front();
          for (int m = 0; m < 8; m++) begin
            got_spd  = m_axis_tdata[m*12 +: 12];
            want_spd = want[m*12 +: 12];
            if (got_spd !== want_spd) begin
              mismatches++;
              $display("%0t: speed_m%0d expected %0d actual %0d",
                       $time, m + 1, want_spd, got_spd);
            end
          end
        end
      end
    end
    outstanding = speeds_due.size();
  end

endmodule

[tb/sv/tb_multirotor_motor_mixer_top.sv]
// Testbench top for the motor mixer: clock, reset, stimulus, output back-pressure and verdict
module tb_multirotor_motor_mixer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 255;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // thrust, roll_cmd, pitch_cmd, yaw_cmd, new_flight_state
  logic [1:0]  s_axis_tuser;   // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // speed_m1 .. speed_m8, 12 bits each
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_wdata;
  int          mismatches;
  int          outstanding;
  bit          idling = 1'b1;
  bit          hold_off_req = 1'b0;

  multirotor_motor_mixer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  mmm_mixer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #3_000_000;
    $display("tb_multirotor_motor_mixer_top: errors");
    $finish;
  end

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer
  task automatic drive(input logic [1:0] act, input logic [15:0] th, input logic [15:0] r,
                       input logic [15:0] p, input logic [15:0] y, input logic [2:0] fs);
    if (idling && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, fs, y, p, r, th};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Command or stick value: full range, near zero, extremes or within full deflection
  function automatic logic [15:0] rand_cmd();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 6400) - 3200);
      2: begin
        case ($urandom_range(0, 3))
          0:       return 16'h7fff;
          1:       return 16'h8000;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom_range(0, 2880) - 1440);
    endcase
  endfunction

  // Favour mixes and ticks, and the flight states that answer a tick
  task automatic send_random();
    logic [1:0] act;
    logic [2:0] fs;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      act = mmm_pkg::ACT_MIX;
    else if (pick < 70)
      act = mmm_pkg::ACT_TICK;
    else if (pick < 85)
      act = mmm_pkg::ACT_FSTATE;
    else
      act = mmm_pkg::ACT_STICK;
    fs = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
    drive(act, rand_cmd(), rand_cmd(), rand_cmd(), rand_cmd(), fs);
  endtask

  // Wait until every predicted result has left, then let the pipeline settle
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_speeds(input logic [11:0] lo, input logic [11:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= mmm_pkg::CFG_MIN_SPEED;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= mmm_pkg::CFG_MAX_SPEED;
    cfg_wdata <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Reprogram the speed range while idle, then run a batch of random items,
  // optionally with the receiver holding off while the batch is offered
  task automatic run_phase(input logic [11:0] lo, input logic [11:0] hi, input bit hold);
    wait_drained();
    set_speeds(lo, hi);
    if (hold)
      hold_off_req = 1'b1;
    repeat (PHASE_ITEMS) send_random();
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= mmm_pkg::ACT_MIX;
    cfg_we        <= 1'b0;
    cfg_index     <= mmm_pkg::CFG_MIN_SPEED;
    cfg_wdata     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset range, command extremes, every flight state on a tick
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_MIX,    16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_MIX,    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_MIX,    16'h8000, 16'h8000, 16'h8000, 16'h8000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_MIX,    16'hffe7, 16'h7fff, 16'h8000, 16'h7fff, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_FSTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_ARMED);
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_FSTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_READY);
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    // Sticks past full deflection, at full deflection and below zero
    drive(mmm_pkg::ACT_STICK,  16'h7fff, 16'h8000, 16'd1440, 16'hfa60, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_FSTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_TESTING);
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_STICK,  16'h0000, 16'hffff, 16'd16,   16'd100,  mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_STICK,  16'hfff0, 16'd719,  16'd2000, 16'hff00, mmm_pkg::FM_DISARMED);
    drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    // Takeoff, flying, landing and other stay silent on a tick
    for (int s = 4; s < 8; s++) begin
      drive(mmm_pkg::ACT_FSTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'(s));
      drive(mmm_pkg::ACT_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, mmm_pkg::FM_DISARMED);
    end
    s_axis_tvalid <= 1'b0;

    // Random: range extremes, min above max, two random ranges, then reset values
    run_phase(12'd0, 12'd4095, 1'b0);
    run_phase(12'd4095, 12'd0, 1'b1);
    run_phase(12'd4095, 12'd4095, 1'b0);
    run_phase(12'd0, 12'd0, 1'b0);
    run_phase(12'($urandom), 12'($urandom), 1'b0);
    run_phase(12'($urandom_range(0, 1000)), 12'($urandom_range(1000, 4095)), 1'b0);
    idling = 1'b0;
    run_phase(12'd150, 12'd1800, 1'b0);
    wait_drained();

    if (mismatches == 0)
      $display("tb_multirotor_motor_mixer_top: clean");
    else
      $display("tb_multirotor_motor_mixer_top: errors");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/mmm_pkg.sv
rtl/mmm_lane.sv
rtl/multirotor_motor_mixer_top.sv
rtl/mmm_checker.sv
tb/sv/mmm_mixer_checker.sv
tb/sv/tb_multirotor_motor_mixer_top.sv
